>>> sv/siq_pkg.sv
// Shared types and constants for the sorted insertion queue.
// No dependencies; every other file of the block imports this package.
package siq_pkg;

    // Default configuration
    localparam int SIQ_DEPTH     = 16;
    localparam int SIQ_TIME_BITS = 16;

    // Fixed field widths of the request and response channels
    localparam int FIELD_W = 16;
    localparam int OCC_W   = 5;

    // Operation codes
    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } t_func;

    // Completion codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Request payload
    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] arrival_time;
        logic [FIELD_W-1:0] service_time;
    } t_req;

    // Response payload
    typedef struct packed {
        logic               popped_valid;
        logic [FIELD_W-1:0] popped_arrival;
        logic [FIELD_W-1:0] popped_service;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_rsp;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

>>> sv/siq_req_if.sv
// Request channel of the sorted insertion queue: valid/ready plus payload.
// Depends on siq_pkg.
interface siq_req_if
    import siq_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/siq_rsp_if.sv
// Response channel of the sorted insertion queue: valid/ready plus payload.
// Depends on siq_pkg.
interface siq_rsp_if
    import siq_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/siq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on siq_pkg for the control struct.
module siq_cell
    import siq_pkg::*;
#(
    parameter int TIME_BITS = SIQ_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    input  logic [TIME_BITS-1:0] i_new_key,
    input  logic [FIELD_W-1:0]   i_new_svc,
    input  logic                 i_left_valid,
    input  logic [TIME_BITS-1:0] i_left_key,
    input  logic [FIELD_W-1:0]   i_left_svc,
    input  logic                 i_left_take,
    input  logic                 i_right_valid,
    input  logic [TIME_BITS-1:0] i_right_key,
    input  logic [FIELD_W-1:0]   i_right_svc,
    output logic                 o_valid,
    output logic [TIME_BITS-1:0] o_key,
    output logic [FIELD_W-1:0]   o_svc,
    output logic                 o_take
);

    logic                 r_valid;
    logic [TIME_BITS-1:0] r_key;
    logic [FIELD_W-1:0]   r_svc;
    logic                 n_valid;
    logic [TIME_BITS-1:0] n_key;
    logic [FIELD_W-1:0]   n_svc;

    // This slot moves on an insert if it is empty or the new key sorts before it
    assign o_take = !r_valid || (i_new_key <= r_key);

    // Next slot contents
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_svc   = r_svc;
        if (i_ctl.ins && o_take) begin
            if (i_left_take) begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
                n_svc   = i_left_svc;
            end else begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_svc   = i_new_svc;
            end
        end else if (i_ctl.pop) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_svc   = i_right_svc;
        end
    end

    // Valid flag is control state; entry data needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_svc <= n_svc;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_svc   = r_svc;

endmodule

>>> sv/sorted_insertion_queue.sv
// Sorted insertion queue: usage notes
// Request channel i_req carries func (insert or pop), arrival_time and
// service_time; response channel o_rsp returns exactly one response per
// request with the popped entry, a status code and the occupancy after
// the operation.
// Entries sit in a row of DEPTH cells kept in ascending arrival-time order,
// head in cell 0. An insert is decided in every cell at once by comparing
// the new key with the cell's own and shifting the tail one cell right;
// a pop shifts every cell one place left. Among equal keys the newest
// entry goes first.
// The response is registered and appears in the cycle after the request
// is accepted. Throughput: one request per cycle while the receiver does
// not stall, set by the single compare-and-shift step of the cell row.
// A response waiting in the output register still lets a new request in
// when o_rsp.ready is high in the same cycle; while the receiver stalls
// with a response pending, i_req.ready stays low.
// Reset (i_rst_n low, synchronous) empties the queue and drops any
// pending response; no clearing pass is needed.
// Depends on siq_pkg, siq_req_if, siq_rsp_if and siq_cell.
module sorted_insertion_queue
    import siq_pkg::*;
#(
    parameter int DEPTH     = SIQ_DEPTH,
    parameter int TIME_BITS = SIQ_TIME_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    siq_req_if.sink    i_req,
    siq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 c_valid [DEPTH];
    logic [TIME_BITS-1:0] c_key   [DEPTH];
    logic [FIELD_W-1:0]   c_svc   [DEPTH];
    logic                 c_take  [DEPTH];

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_rsp_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;

    logic                 accept;
    logic                 is_pop;
    logic                 full;
    logic                 empty;
    t_cell_ctl            ctl;
    logic [TIME_BITS-1:0] new_key;

    // Handshake: one output register separates the two sides
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign is_pop  = (i_req.payload.func == FUNC_POP);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign new_key = TIME_BITS'(i_req.payload.arrival_time);

    assign ctl.ins = accept && !is_pop && !full;
    assign ctl.pop = accept && is_pop && !empty;

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 left_valid;
        logic [TIME_BITS-1:0] left_key;
        logic [FIELD_W-1:0]   left_svc;
        logic                 left_take;
        logic                 right_valid;
        logic [TIME_BITS-1:0] right_key;
        logic [FIELD_W-1:0]   right_svc;

        if (g == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_key   = '0;
            assign left_svc   = '0;
            assign left_take  = 1'b0;
        end else begin : g_mid
            assign left_valid = c_valid[g-1];
            assign left_key   = c_key[g-1];
            assign left_svc   = c_svc[g-1];
            assign left_take  = c_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_key   = '0;
            assign right_svc   = '0;
        end else begin : g_body
            assign right_valid = c_valid[g+1];
            assign right_key   = c_key[g+1];
            assign right_svc   = c_svc[g+1];
        end

        siq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new_key     (new_key),
            .i_new_svc     (i_req.payload.service_time),
            .i_left_valid  (left_valid),
            .i_left_key    (left_key),
            .i_left_svc    (left_svc),
            .i_left_take   (left_take),
            .i_right_valid (right_valid),
            .i_right_key   (right_key),
            .i_right_svc   (right_svc),
            .o_valid       (c_valid[g]),
            .o_key         (c_key[g]),
            .o_svc         (c_svc[g]),
            .o_take        (c_take[g])
        );
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Response for the accepted request
    always_comb begin
        n_rsp                = '0;
        n_rsp.occupancy      = OCC_W'(n_count);
        n_rsp.status         = ST_DONE;
        if (is_pop) begin
            if (empty) begin
                n_rsp.status = ST_EMPTY;
            end else begin
                n_rsp.popped_valid   = 1'b1;
                n_rsp.popped_arrival = FIELD_W'(c_key[0]);
                n_rsp.popped_service = c_svc[0];
            end
        end else if (full) begin
            n_rsp.status = ST_FULL;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

>>> sv/siq_checker.sv
// Port-level checks for the sorted insertion queue, bound to the top level.
// Depends on siq_pkg and sorted_insertion_queue.
module siq_checker
    import siq_pkg::*;
#(
    parameter int DEPTH = SIQ_DEPTH
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    // A stalled response holds its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response changed while stalled");

    // An entry is only returned on a successful pop
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.popped_valid |-> i_rsp.status == ST_DONE)
        else $error("popped entry with error status");

    // Error responses carry no entry
    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status != ST_DONE |->
            !i_rsp.popped_valid && i_rsp.popped_arrival == '0
            && i_rsp.popped_service == '0)
        else $error("error response carries entry data");

    // Occupancy agrees with the error kind
    a_occ_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status == ST_EMPTY || i_rsp.status == ST_FULL) |->
            i_rsp.occupancy == ((i_rsp.status == ST_EMPTY) ? OCC_W'(0) : OCC_W'(DEPTH)))
        else $error("occupancy does not match status");

    // A request is accepted only while no stalled response blocks it
    a_req_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !(i_req_valid && i_req_ready))
        else $error("request accepted over a stalled response");

endmodule

bind sorted_insertion_queue siq_checker #(
    .DEPTH (DEPTH)
) u_siq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

>>> sim/tb_top.sv
// Self-checking testbench for the sorted insertion queue.
// Depends on siq_pkg, siq_req_if, siq_rsp_if and the sorted_insertion_queue RTL.
`timescale 1ns / 1ps

module tb_top;
    import siq_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int Q_DEPTH      = SIQ_DEPTH;
    localparam int MAX_PRINTS   = 50;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Clock: 20 ns period
    always #(HALF_PERIOD) i_clk = ~i_clk;

    siq_req_if req_if ();
    siq_rsp_if rsp_if ();

    sorted_insertion_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Traffic shaping knobs
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_cycles;

    // Bookkeeping
    int cycle_count    = 0;
    int mismatch_count = 0;

    // Predicted queue contents, head in slot 0
    logic [FIELD_W-1:0] sched_key [Q_DEPTH];
    logic [FIELD_W-1:0] sched_svc [Q_DEPTH];
    int                 sched_count = 0;

    // Responses predicted but not yet seen
    t_rsp outstanding_rsp [$];
    t_rsp want_rsp;

    // Apply one request to the predicted queue and return the response it yields
    function automatic t_rsp apply_request(t_req r);
        t_rsp rsp;
        int   pos;
        int   i;
        rsp = '0;
        if (r.func == FUNC_INSERT) begin
            if (sched_count >= Q_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                // in front of the first key >= new key, so newest wins ties
                pos = 0;
                while (pos < sched_count && r.arrival_time > sched_key[pos])
                    pos++;
                for (i = sched_count; i > pos; i--) begin
                    sched_key[i] = sched_key[i-1];
                    sched_svc[i] = sched_svc[i-1];
                end
                sched_key[pos] = r.arrival_time;
                sched_svc[pos] = r.service_time;
                sched_count++;
                rsp.status = ST_DONE;
            end
        end else if (sched_count == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            rsp.popped_valid   = 1'b1;
            rsp.popped_arrival = sched_key[0];
            rsp.popped_service = sched_svc[0];
            for (i = 1; i < sched_count; i++) begin
                sched_key[i-1] = sched_key[i];
                sched_svc[i-1] = sched_svc[i];
            end
            sched_count--;
            rsp.status = ST_DONE;
        end
        rsp.occupancy = OCC_W'(sched_count);
        return rsp;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // Response check first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (outstanding_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want_rsp = outstanding_rsp.pop_front();
                    if (rsp_if.payload.popped_valid !== want_rsp.popped_valid)
                        report_mismatch($sformatf("popped_valid got %0b want %0b",
                            rsp_if.payload.popped_valid, want_rsp.popped_valid));
                    if (rsp_if.payload.popped_arrival !== want_rsp.popped_arrival)
                        report_mismatch($sformatf("popped_arrival got %h want %h",
                            rsp_if.payload.popped_arrival, want_rsp.popped_arrival));
                    if (rsp_if.payload.popped_service !== want_rsp.popped_service)
                        report_mismatch($sformatf("popped_service got %h want %h",
                            rsp_if.payload.popped_service, want_rsp.popped_service));
                    if (rsp_if.payload.status !== want_rsp.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            rsp_if.payload.status, want_rsp.status));
                    if (rsp_if.payload.occupancy !== want_rsp.occupancy)
                        report_mismatch($sformatf("occupancy got %0d want %0d",
                            rsp_if.payload.occupancy, want_rsp.occupancy));
                end
            end
            if (req_if.valid && req_if.ready)
                outstanding_rsp.push_back(apply_request(req_if.payload));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver: long hold-off when asked, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles  <= hold_cycles - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one request after random idle cycles; returns once it is taken
    task automatic send_request(t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_fields(t_func f, logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] svc);
        t_req r;
        r.func         = f;
        r.arrival_time = key;
        r.service_time = svc;
        send_request(r);
    endtask

    task automatic end_requests();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    // Wait for every predicted response, then let the pipeline settle
    task automatic wait_drain();
        while (outstanding_rsp.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Keys lean on duplicates and extremes so tie ordering gets exercised
    function automatic t_req random_request(int insert_pct);
        t_req r;
        r.func = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_POP;
        case ($urandom_range(3))
            0: r.arrival_time = FIELD_W'($urandom_range(7));
            1: begin
                case ($urandom_range(3))
                    0:       r.arrival_time = 16'h0000;
                    1:       r.arrival_time = 16'h0001;
                    2:       r.arrival_time = 16'hFFFE;
                    default: r.arrival_time = 16'hFFFF;
                endcase
            end
            default: r.arrival_time = FIELD_W'($urandom);
        endcase
        r.service_time = FIELD_W'($urandom);
        return r;
    endfunction

    // Empty pop, fill with extremes and ties, overfill, then partial drain
    task automatic test_directed_cases();
        logic [FIELD_W-1:0] fill_key [16] = '{
            16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0001,
            16'hFFFE, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8000,
            16'h0001, 16'h7FFF, 16'h0000, 16'hFFFF};
        logic [FIELD_W-1:0] fill_svc [16] = '{
            16'h1111, 16'hFFFF, 16'h0000, 16'h2222, 16'h3333, 16'hAAAA,
            16'h5555, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h4444,
            16'hFFFE, 16'h0F0F, 16'hF0F0, 16'h1234};
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_fields(FUNC_POP, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 16; k++)
            send_fields(FUNC_INSERT, fill_key[k], fill_svc[k]);
        send_fields(FUNC_INSERT, 16'h1234, 16'h5678);
        for (int k = 0; k < 6; k++)
            send_fields(FUNC_POP, FIELD_W'($urandom), FIELD_W'($urandom));
        end_requests();
        wait_drain();
    endtask

    // Random mix; the insert share changes every few dozen requests so the
    // queue swings between empty and full
    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_req);
        int insert_pct;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        insert_pct         = 50;
        for (int n = 0; n < n_req; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(3))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    2:       insert_pct = 80;
                    default: insert_pct = 95;
                endcase
            end
            send_request(random_request(insert_pct));
        end
        end_requests();
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles        = 300;
        for (int n = 0; n < 40; n++)
            send_request(random_request(80));
        end_requests();
        wait_drain();
    endtask

    initial begin
        req_if.valid       = 1'b0;
        req_if.payload     = '0;
        rsp_if.ready       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles        = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(0, 0, 200);
        test_random_traffic(67, 0, 200);
        test_random_traffic(0, 67, 200);
        test_backpressure();
        test_random_traffic(29, 29, 200);

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding_rsp.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
